// File: rtl/core/ttt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and constants for the timeout table tick core.
// ----------------------------------------------------------------------------
package ttt_pkg;

	localparam int SLOTS      = 32;
	localparam int TABLE_SIZE = (SLOTS < 32) ? SLOTS : 32;
	localparam int SLOT_AW    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 5;
	localparam int PERIOD_W = 32;
	localparam int MS_W     = 10;
	localparam int RAM_W    = 2 * PERIOD_W;

	localparam logic [MS_W-1:0] MS_RESET = MS_W'(10);

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK   = 2'd0,
		KIND_ARM    = 2'd1,
		KIND_CANCEL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		EV_ARMED     = 2'd0,
		EV_CANCELLED = 2'd1,
		EV_IDLE      = 2'd2,
		EV_EXPIRED   = 2'd3
	} ev_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SLOT_W-1:0]   slot;
		logic [PERIOD_W-1:0] period;
		logic                periodic;
	} item_t;

	typedef struct packed {
		ev_code_t          event_res;
		logic [SLOT_W-1:0] which_slot;
		logic              was_periodic;
		logic              last;
	} result_t;

endpackage

// File: rtl/core/ttt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ttt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/timeout_table_tick_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timeout_table_tick_core
// Table of timeout slots: arm, cancel and periodic tick with expiry events.
// ----------------------------------------------------------------------------
//  channel   | signals                         | transfer
//  ----------+---------------------------------+-------------------------------
//  command   | start, busy, item               | start & !busy
//  result    | strobe, result                  | strobe (no backpressure)
//  config    | cfg_valid, cfg_ready, cfg_data  | cfg_valid & cfg_ready
//
//  Arm and cancel never raise busy; the result appears the cycle after transfer.
//  A tick holds busy through scan, tail and flush: one slot per cycle
//  through the period/elapsed RAM read port, then a pipeline tail and a flush
//  of the held last expiry. Expiries stream out in slot order during the tick.
//  Reset clears all slot flags at once; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module timeout_table_tick_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ttt_pkg::item_t                item,
	output logic                          strobe,
	output ttt_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ttt_pkg::MS_W-1:0]      cfg_data
);

	ttt_pkg::state_t state_q, state_d;

	logic [ttt_pkg::SLOT_AW-1:0]     cnt_q;
	logic [ttt_pkg::MS_W-1:0]        ms_q;
	logic [ttt_pkg::TABLE_SIZE-1:0]  active_q;
	logic [ttt_pkg::TABLE_SIZE-1:0]  periodic_q;

	logic                            valid_s1;
	logic [ttt_pkg::SLOT_AW-1:0]     slot_s1;

	logic                            pend_valid_q;
	logic [ttt_pkg::SLOT_AW-1:0]     pend_slot_q;
	logic                            pend_per_q;

	logic                            strobe_q;
	ttt_pkg::result_t                result_q;

	logic                            accept;
	logic                            in_range;
	logic [ttt_pkg::SLOT_AW-1:0]     item_idx;
	logic                            do_arm;
	logic                            do_cancel;
	logic                            do_tick;

	logic                            rd_en;
	logic                            wr_en;
	logic [ttt_pkg::SLOT_AW-1:0]     wr_addr;
	logic [ttt_pkg::RAM_W-1:0]       wr_data;
	logic [ttt_pkg::RAM_W-1:0]       rd_data;

	logic [ttt_pkg::PERIOD_W-1:0]    per_s1;
	logic [ttt_pkg::PERIOD_W-1:0]    el_s1;
	logic [ttt_pkg::PERIOD_W:0]      sum_s1;
	logic [ttt_pkg::PERIOD_W-1:0]    sat_s1;
	logic                            live_s1;
	logic                            expire_s1;
	logic [ttt_pkg::PERIOD_W-1:0]    new_el_s1;

	assign accept    = start && !busy;
	assign in_range  = 32'(item.slot) < ttt_pkg::TABLE_SIZE;
	assign item_idx  = item.slot[ttt_pkg::SLOT_AW-1:0];
	assign do_arm    = accept && (item.kind == ttt_pkg::KIND_ARM) && in_range;
	assign do_cancel = accept && (item.kind == ttt_pkg::KIND_CANCEL);
	assign do_tick   = accept && (item.kind == ttt_pkg::KIND_TICK);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttt_pkg::ST_IDLE: begin
				if (do_tick) state_d = ttt_pkg::ST_SCAN;
			end
			ttt_pkg::ST_SCAN: begin
				if (cnt_q == ttt_pkg::SLOT_AW'(ttt_pkg::TABLE_SIZE - 1)) begin
					state_d = ttt_pkg::ST_TAIL;
				end
			end
			ttt_pkg::ST_TAIL:  state_d = ttt_pkg::ST_FLUSH;
			ttt_pkg::ST_FLUSH: state_d = ttt_pkg::ST_IDLE;
			default:           state_d = ttt_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		busy      = (state_q != ttt_pkg::ST_IDLE);
		cfg_ready = (state_q == ttt_pkg::ST_IDLE);
		rd_en     = (state_q == ttt_pkg::ST_SCAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttt_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ttt_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= ttt_pkg::MS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ms_q <= cfg_data;
		end
	end

	// period/elapsed store, {period, elapsed}
	ttt_ram #(
		.WIDTH(ttt_pkg::RAM_W),
		.DEPTH(ttt_pkg::TABLE_SIZE)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(cnt_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= cnt_q;
	end

	// tick update of one slot
	always_comb begin
		per_s1    = rd_data[ttt_pkg::RAM_W-1:ttt_pkg::PERIOD_W];
		el_s1     = rd_data[ttt_pkg::PERIOD_W-1:0];
		sum_s1    = {1'b0, el_s1} + (ttt_pkg::PERIOD_W + 1)'(ms_q);
		sat_s1    = sum_s1[ttt_pkg::PERIOD_W] ? '1 : sum_s1[ttt_pkg::PERIOD_W-1:0];
		live_s1   = valid_s1 && active_q[slot_s1] && (per_s1 != '0);
		expire_s1 = live_s1 && (sat_s1 >= per_s1);
		new_el_s1 = expire_s1 ? '0 : sat_s1;
	end

	always_comb begin
		if (live_s1) begin
			wr_en   = 1'b1;
			wr_addr = slot_s1;
			wr_data = {per_s1, new_el_s1};
		end else begin
			wr_en   = do_arm;
			wr_addr = item_idx;
			wr_data = {item.period, ttt_pkg::PERIOD_W'(0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			periodic_q <= '0;
		end else begin
			if (do_arm) begin
				active_q[item_idx]   <= 1'b1;
				periodic_q[item_idx] <= item.periodic;
			end else if (do_cancel && in_range) begin
				active_q[item_idx]   <= 1'b0;
				periodic_q[item_idx] <= 1'b0;
			end else if (expire_s1 && !periodic_q[slot_s1]) begin
				active_q[slot_s1]    <= 1'b0;
				periodic_q[slot_s1]  <= 1'b0;
			end
		end
	end

	// one expiry is held back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (state_q == ttt_pkg::ST_FLUSH) begin
			pend_valid_q <= 1'b0;
		end else if (expire_s1) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (expire_s1) begin
			pend_slot_q <= slot_s1;
			pend_per_q  <= periodic_q[slot_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= do_arm || do_cancel || (expire_s1 && pend_valid_q)
				|| ((state_q == ttt_pkg::ST_FLUSH) && pend_valid_q);
		end
	end

	always_ff @(posedge clk) begin
		if (do_arm) begin
			result_q.event_res    <= ttt_pkg::EV_ARMED;
			result_q.which_slot   <= item.slot;
			result_q.was_periodic <= item.periodic;
			result_q.last         <= 1'b1;
		end else if (do_cancel) begin
			result_q.event_res    <= (in_range && active_q[item_idx]) ?
				ttt_pkg::EV_CANCELLED : ttt_pkg::EV_IDLE;
			result_q.which_slot   <= item.slot;
			result_q.was_periodic <= 1'b0;
			result_q.last         <= 1'b1;
		end else if (pend_valid_q && (expire_s1 || (state_q == ttt_pkg::ST_FLUSH))) begin
			result_q.event_res    <= ttt_pkg::EV_EXPIRED;
			result_q.which_slot   <= ttt_pkg::SLOT_W'(pend_slot_q);
			result_q.was_periodic <= pend_per_q;
			result_q.last         <= (state_q == ttt_pkg::ST_FLUSH);
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_busy_ends_after_flush: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(state_q == ttt_pkg::ST_FLUSH))
		else $error("busy dropped outside flush");

	a_single_results_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.event_res != ttt_pkg::EV_EXPIRED) |-> result.last)
		else $error("arm or cancel result without last");

	a_tick_last_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last && (result.event_res == ttt_pkg::EV_EXPIRED)
			|-> $past(state_q == ttt_pkg::ST_FLUSH))
		else $error("final expiry not from flush");

	a_idle_nothing_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttt_pkg::ST_IDLE) |-> !pend_valid_q && !valid_s1)
		else $error("tick state left over in idle");

	a_pipe_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ttt_pkg::ST_SCAN) || (state_q == ttt_pkg::ST_TAIL))
		else $error("slot update outside tick");

endmodule

// File: tb/timeout_table_tick_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timeout_table_tick_core_tb
// Self-checking bench for the timeout slot table. A queue of commands and
// ms_per_tick writes, filled up front, feeds a clocked driver with random
// gaps. An in-bench slot table predicts every armed, cancelled, idle-cancel
// and expiry event, and a clocked monitor checks each strobed result in order.
// ----------------------------------------------------------------------------
module timeout_table_tick_core_tb;
	import ttt_pkg::*;

	localparam int  SETTLE   = TABLE_SIZE + 8;
	localparam int  DRAIN    = 4 * (TABLE_SIZE + 2);
	localparam time LIMIT_NS = 5_000_000;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		bit              is_cfg;
		logic [MS_W-1:0] ms;
		item_t           cmd;
	} request_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            start     = 1'b0;
	item_t           item      = '0;
	logic            cfg_valid = 1'b0;
	logic [MS_W-1:0] cfg_data  = '0;
	logic            busy;
	logic            strobe;
	result_t         result;
	logic            cfg_ready;

	timeout_table_tick_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// predicted slot table
	logic [MS_W-1:0]     tick_ms = MS_RESET;
	logic                tbl_active   [TABLE_SIZE];
	logic                tbl_periodic [TABLE_SIZE];
	logic [PERIOD_W-1:0] tbl_period   [TABLE_SIZE];
	logic [PERIOD_W-1:0] tbl_elapsed  [TABLE_SIZE];

	request_t cmd_backlog[$];
	result_t  exp_events[$];
	int       gen_count  = 0;
	int       mismatches = 0;

	initial begin
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tbl_active[i]   = 1'b0;
			tbl_periodic[i] = 1'b0;
			tbl_period[i]   = '0;
			tbl_elapsed[i]  = '0;
		end
	end

	task automatic predict_events(input item_t cmd);
		result_t             evs[$];
		result_t             ev;
		logic [PERIOD_W:0]   sum;
		ev = '0;
		case (cmd.kind)
			KIND_TICK: begin
				for (int i = 0; i < TABLE_SIZE; i++) begin
					if (tbl_active[i] && tbl_period[i] != 0) begin
						sum = {1'b0, tbl_elapsed[i]} + (PERIOD_W + 1)'(tick_ms);
						tbl_elapsed[i] = sum[PERIOD_W] ? '1 : sum[PERIOD_W-1:0];
						if (tbl_elapsed[i] >= tbl_period[i]) begin
							ev.event_res    = EV_EXPIRED;
							ev.which_slot   = SLOT_W'(i);
							ev.was_periodic = tbl_periodic[i];
							ev.last         = 1'b0;
							evs.push_back(ev);
							if (tbl_periodic[i]) begin
								tbl_elapsed[i] = '0;
							end else begin
								tbl_active[i]   = 1'b0;
								tbl_periodic[i] = 1'b0;
							end
						end
					end
				end
			end
			KIND_ARM: begin
				if (cmd.slot < TABLE_SIZE) begin
					tbl_active[cmd.slot]   = 1'b1;
					tbl_periodic[cmd.slot] = cmd.periodic;
					tbl_period[cmd.slot]   = cmd.period;
					tbl_elapsed[cmd.slot]  = '0;
					ev.event_res    = EV_ARMED;
					ev.which_slot   = cmd.slot;
					ev.was_periodic = cmd.periodic;
					evs.push_back(ev);
				end
			end
			KIND_CANCEL: begin
				ev.which_slot = cmd.slot;
				if (cmd.slot < TABLE_SIZE && tbl_active[cmd.slot]) begin
					tbl_active[cmd.slot]   = 1'b0;
					tbl_periodic[cmd.slot] = 1'b0;
					ev.event_res = EV_CANCELLED;
				end else begin
					ev.event_res = EV_IDLE;
				end
				evs.push_back(ev);
			end
			default: ;
		endcase
		if (evs.size() > 0)
			evs[evs.size()-1].last = 1'b1;
		foreach (evs[k])
			exp_events.push_back(evs[k]);
	endtask

	// ------------------------------------------------------------------ driver
	int gap_left  = 0;
	int calm_left = 0;
	int settle    = 0;
	int gap_roll;
	bit fire_cmd;
	bit fire_cfg;

	always @(posedge clk) begin
		if (!arst_n) begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			fire_cmd = start && !busy;
			fire_cfg = cfg_valid && cfg_ready;
			if (fire_cmd) begin
				predict_events(item);
				gap_roll = $urandom_range(0, 99);
				if (calm_left > 0) begin
					calm_left--;
					gap_left = 0;
				end else if (gap_roll < 4) begin
					calm_left = $urandom_range(15, 40);
					gap_left  = 0;
				end else if (gap_roll < 45) begin
					gap_left = 0;
				end else if (gap_roll < 90) begin
					gap_left = $urandom_range(1, 4);
				end else begin
					gap_left = $urandom_range(10, 60);
				end
			end
			if (fire_cfg) begin
				tick_ms = cfg_data;
				cfg_valid <= 1'b0;
			end
			if (start && !fire_cmd) begin
				// command held until transfer
			end else if (cfg_valid && !fire_cfg) begin
				// register write held until transfer
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (cmd_backlog.size() == 0) begin
				start <= 1'b0;
			end else if (cmd_backlog[0].is_cfg) begin
				start <= 1'b0;
				if (!start && !busy && !cfg_valid && exp_events.size() == 0)
					settle++;
				else
					settle = 0;
				if (settle >= SETTLE) begin
					cfg_valid <= 1'b1;
					cfg_data  <= cmd_backlog[0].ms;
					cmd_backlog.pop_front();
					settle = 0;
				end
			end else begin
				start <= 1'b1;
				item  <= cmd_backlog[0].cmd;
				cmd_backlog.pop_front();
			end
		end
	end

	// ----------------------------------------------------------------- monitor
	result_t want;

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (exp_events.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: ev=%0d slot=%0d per=%0b last=%0b",
						result.event_res, result.which_slot, result.was_periodic,
						result.last);
				mismatches++;
			end else begin
				want = exp_events.pop_front();
				if (result.event_res !== want.event_res ||
				    result.which_slot !== want.which_slot ||
				    result.was_periodic !== want.was_periodic ||
				    result.last !== want.last) begin
					if (mismatches < 10)
						$display("mismatch ev/slot/per/last: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
							want.event_res, want.which_slot, want.was_periodic,
							want.last, result.event_res, result.which_slot,
							result.was_periodic, result.last);
					mismatches++;
				end
			end
		end
	end

	// --------------------------------------------------------------- stimulus
	task automatic add_cmd(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
	                       input logic [PERIOD_W-1:0] period, input logic periodic);
		request_t rq;
		rq.is_cfg       = 1'b0;
		rq.ms           = '0;
		rq.cmd.kind     = kind;
		rq.cmd.slot     = slot;
		rq.cmd.period   = period;
		rq.cmd.periodic = periodic;
		cmd_backlog.push_back(rq);
		if (kind != KIND_UNUSED)
			gen_count++;
	endtask

	task automatic add_cfg(input logic [MS_W-1:0] ms);
		request_t rq;
		rq.is_cfg = 1'b1;
		rq.ms     = ms;
		rq.cmd    = '0;
		cmd_backlog.push_back(rq);
	endtask

	function automatic logic [PERIOD_W-1:0] rand_period(input int unsigned ms);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		else if (roll < 16)
			return $urandom;
		else if (roll < 20)
			return '1;
		else
			return $urandom_range(1, (ms == 0 ? 1 : ms) * 6);
	endfunction

	// arm a group of slots with short periods, then tick them out
	task automatic arm_burst(input int unsigned ms, input int nslots);
		int span;
		span = (ms == 0 ? 1 : ms) * 2;
		for (int i = 0; i < nslots; i++)
			add_cmd(KIND_ARM, nslots == TABLE_SIZE ? SLOT_W'(i) : SLOT_W'($urandom),
				$urandom_range(1, span), 1'($urandom));
		repeat ($urandom_range(1, 3))
			add_cmd(KIND_TICK, SLOT_W'($urandom), $urandom, 1'($urandom));
	endtask

	task automatic gen_phase(input int unsigned ms, input int n);
		int target;
		int roll;
		target = gen_count + n;
		while (gen_count < target) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				arm_burst(ms, TABLE_SIZE);
			else if (roll < 14)
				arm_burst(ms, $urandom_range(1, 8));
			else if (roll < 42)
				add_cmd(KIND_TICK, SLOT_W'($urandom), $urandom, 1'($urandom));
			else if (roll < 70)
				add_cmd(KIND_ARM, SLOT_W'($urandom), rand_period(ms), 1'($urandom));
			else if (roll < 95)
				add_cmd(KIND_CANCEL, SLOT_W'($urandom), $urandom, 1'($urandom));
			else
				add_cmd(KIND_UNUSED, SLOT_W'($urandom), $urandom, 1'($urandom));
		end
	endtask

	initial begin
		int unsigned ms_pick;

		// directed, at the reset ms_per_tick of 10
		add_cmd(KIND_TICK,   5'd0,  32'd0, 1'b0);            // empty table
		add_cmd(KIND_CANCEL, 5'd0,  32'd0, 1'b0);            // idle cancel
		add_cmd(KIND_CANCEL, 5'd31, '1,    1'b1);            // idle cancel, top slot
		add_cmd(KIND_ARM,    5'd0,  32'd0, 1'b1);            // period 0, never expires
		add_cmd(KIND_ARM,    5'd31, 32'd10, 1'b0);           // one-shot, first tick
		add_cmd(KIND_ARM,    5'd7,  32'd20, 1'b1);
		add_cmd(KIND_ARM,    5'd12, '1,    1'b0);            // longest period
		add_cmd(KIND_UNUSED, 5'd31, '1,    1'b1);            // ignored
		add_cmd(KIND_TICK,   5'd31, '1,    1'b1);
		add_cmd(KIND_TICK,   5'd0,  32'd0, 1'b0);
		add_cmd(KIND_ARM,    5'd7,  32'd15, 1'b0);           // re-arm of active slot
		add_cmd(KIND_TICK,   5'd0,  32'd0, 1'b0);
		add_cmd(KIND_TICK,   5'd0,  32'd0, 1'b0);
		add_cmd(KIND_CANCEL, 5'd12, 32'd0, 1'b0);            // active cancel
		add_cmd(KIND_CANCEL, 5'd12, 32'd0, 1'b0);            // now idle
		add_cmd(KIND_CANCEL, 5'd31, 32'd0, 1'b0);            // freed by expiry
		add_cmd(KIND_ARM,    5'd3,  32'd5, 1'b1);
		add_cmd(KIND_ARM,    5'd4,  32'd5, 1'b0);
		add_cmd(KIND_TICK,   5'd0,  32'd0, 1'b0);            // two expiries
		add_cmd(KIND_TICK,   5'd0,  32'd0, 1'b0);
		add_cmd(KIND_CANCEL, 5'd3,  32'd0, 1'b0);
		add_cmd(KIND_CANCEL, 5'd0,  32'd0, 1'b0);

		add_cfg(10'd1);
		gen_phase(1, 35);
		add_cfg(10'd1000);
		arm_burst(1000, TABLE_SIZE);
		gen_phase(1000, 35);
		add_cfg(10'd0);
		gen_phase(0, 30);
		add_cfg(10'd1023);
		gen_phase(1023, 30);
		ms_pick = $urandom_range(1, 1000);
		add_cfg(MS_W'(ms_pick));
		gen_phase(ms_pick, 45);
		add_cfg(MS_RESET);
		gen_phase(10, 40);
		ms_pick = $urandom_range(1, 1000);
		add_cfg(MS_W'(ms_pick));
		gen_phase(ms_pick, 35);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (cmd_backlog.size() != 0 || start || cfg_valid || busy ||
		       exp_events.size() != 0);
		repeat (DRAIN) @(posedge clk);

		if (mismatches == 0 && exp_events.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
